>>> src/clr_pkg.sv
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the clipped line rasterizer: opcodes,
// configuration register indexes and the color key settings.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;

    // color index that is never written to the framebuffer
    localparam logic [COLOR_BITS-1:0] COLOR_NEVER_DRAWN = 8'hFF;

    // reset value of the exclusive right and bottom clip edges
    localparam int CLIP_RESET_FAR = 256;

    // minimum signed clip edge width; it holds the far clip reset value
    localparam int CLIP_MIN_BITS = 10;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_opcode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_TOP    = 3'd1,
        CFG_CLIP_RIGHT  = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_KEY_ENABLE  = 3'd4,
        CFG_KEY_VALUE   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                  en;
        logic [COLOR_BITS-1:0] value;
    } t_key_cfg;

endpackage

>>> src/clipped_line_rasterizer.sv
// path: input register holds the request, output register holds its point
// throughput: one request per cycle while points are taken; the Bresenham
//   state loop closes in the single logic stage between the in/out registers
// reset: synchronous active low; no line running, clip 0..256 in x and y,
//   color key off, input and output registers empty
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Integer Bresenham line stepper. A load request latches the endpoints and
// color and emits the start point; each step request emits the next point
// until the end point has gone out. Each point carries a drawn flag.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [COORD_BITS-1:0]         i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic signed [COORD_BITS-1:0]  i_x_start,
    input  logic signed [COORD_BITS-1:0]  i_y_start,
    input  logic signed [COORD_BITS-1:0]  i_x_end,
    input  logic signed [COORD_BITS-1:0]  i_y_end,
    input  logic [COLOR_BITS-1:0]         i_color_in,
    // point channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_px,
    output logic signed [COORD_BITS-1:0]  o_py,
    output logic [COLOR_BITS-1:0]         o_color_out,
    output logic                          o_drawn,
    output logic                          o_last
);

    // differences and step sizes need one more bit than a coordinate,
    // the error term three more, and twice the error term four more
    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;
    // clip edges must hold the far reset value even for narrow coordinates
    localparam int CW = (COORD_BITS < CLIP_MIN_BITS) ? CLIP_MIN_BITS : COORD_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_clip_left;
    logic signed [CW-1:0] r_clip_top;
    logic signed [CW-1:0] r_clip_right;
    logic signed [CW-1:0] r_clip_bottom;
    t_key_cfg             r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= CW'(CLIP_RESET_FAR);
            r_clip_bottom <= CW'(CLIP_RESET_FAR);
            r_key         <= '0;
        end else if (i_cfg_we) begin
            // clip edges are sign-extended from the coordinate width
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLIP_LEFT:   r_clip_left   <= CW'($signed(i_cfg_data));
                CFG_CLIP_TOP:    r_clip_top    <= CW'($signed(i_cfg_data));
                CFG_CLIP_RIGHT:  r_clip_right  <= CW'($signed(i_cfg_data));
                CFG_CLIP_BOTTOM: r_clip_bottom <= CW'($signed(i_cfg_data));
                CFG_KEY_ENABLE:  r_key.en      <= i_cfg_data[0];
                CFG_KEY_VALUE:   r_key.value   <= i_cfg_data[COLOR_BITS-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register: request fields plus the endpoint differences
    // ------------------------------------------------------------------
    logic                  r_in_vld;
    t_opcode               r_in_op;
    logic signed [DW-1:0]  r_in_xs;
    logic signed [DW-1:0]  r_in_ys;
    logic signed [DW-1:0]  r_in_xe;
    logic signed [DW-1:0]  r_in_ye;
    logic signed [DW-1:0]  r_in_dx;
    logic signed [DW-1:0]  r_in_dy;
    logic [COLOR_BITS-1:0] r_in_color;

    logic out_free;
    logic fire;

    // output slot frees when empty or when its point is taken this cycle
    assign out_free   = !o_out_valid || i_out_ready;
    assign fire       = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op    <= t_opcode'(i_opcode);
            r_in_xs    <= DW'(i_x_start);
            r_in_ys    <= DW'(i_y_start);
            r_in_xe    <= DW'(i_x_end);
            r_in_ye    <= DW'(i_y_end);
            r_in_dx    <= DW'(i_x_end) - DW'(i_x_start);
            r_in_dy    <= DW'(i_y_end) - DW'(i_y_start);
            r_in_color <= i_color_in;
        end
    end

    // ------------------------------------------------------------------
    // line state
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic signed [COORD_BITS-1:0] r_end_x;
    logic signed [COORD_BITS-1:0] r_end_y;
    logic signed [DW-1:0]         r_abs_dx;
    logic signed [DW-1:0]         r_neg_abs_dy;
    logic                         r_step_x_neg;
    logic                         r_step_y_neg;
    logic signed [EW-1:0]         r_err;
    logic [COLOR_BITS-1:0]        r_color;
    logic                         r_active;

    // ------------------------------------------------------------------
    // single logic stage: pick loaded or running line, emit, advance
    // ------------------------------------------------------------------
    logic                         is_load;
    logic                         has_result;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic signed [DW-1:0]         ax;
    logic signed [DW-1:0]         nay;
    logic                         sxn;
    logic                         syn;
    logic signed [EW-1:0]         err;
    logic [COLOR_BITS-1:0]        color;
    logic                         is_last;
    logic signed [EW:0]           e2;
    logic                         move_x;
    logic                         move_y;
    logic signed [EW-1:0]         n_err;
    logic signed [COORD_BITS-1:0] n_cur_x;
    logic signed [COORD_BITS-1:0] n_cur_y;
    logic                         drawn;

    assign is_load    = (r_in_op == OP_LOAD);
    assign has_result = is_load || r_active;

    always_comb begin
        if (is_load) begin
            cx    = r_in_xs[COORD_BITS-1:0];
            cy    = r_in_ys[COORD_BITS-1:0];
            ex    = r_in_xe[COORD_BITS-1:0];
            ey    = r_in_ye[COORD_BITS-1:0];
            ax    = r_in_dx[DW-1] ? -r_in_dx : r_in_dx;
            nay   = r_in_dy[DW-1] ? r_in_dy : -r_in_dy;
            // step goes negative unless the end lies strictly ahead
            sxn   = r_in_dx[DW-1] || (r_in_dx == '0);
            syn   = r_in_dy[DW-1] || (r_in_dy == '0);
            err   = EW'(ax) + EW'(nay);
            color = r_in_color;
        end else begin
            cx    = r_cur_x;
            cy    = r_cur_y;
            ex    = r_end_x;
            ey    = r_end_y;
            ax    = r_abs_dx;
            nay   = r_neg_abs_dy;
            sxn   = r_step_x_neg;
            syn   = r_step_y_neg;
            err   = r_err;
            color = r_color;
        end
    end

    assign is_last = (cx == ex) && (cy == ey);
    assign e2      = $signed({err, 1'b0});
    assign move_x  = (e2 >= (EW + 1)'(nay));
    assign move_y  = (e2 <= (EW + 1)'(ax));
    assign n_err   = err + (move_x ? EW'(nay) : EW'(0)) + (move_y ? EW'(ax) : EW'(0));
    assign n_cur_x = move_x ? (sxn ? cx - 1'b1 : cx + 1'b1) : cx;
    assign n_cur_y = move_y ? (syn ? cy - 1'b1 : cy + 1'b1) : cy;

    clr_clip_test #(
        .COORD_BITS (COORD_BITS),
        .CLIP_BITS  (CW)
    ) u_clip (
        .i_x           (cx),
        .i_y           (cy),
        .i_color       (color),
        .i_clip_left   (r_clip_left),
        .i_clip_top    (r_clip_top),
        .i_clip_right  (r_clip_right),
        .i_clip_bottom (r_clip_bottom),
        .i_key         (r_key),
        .o_drawn       (drawn)
    );

    // state follows every request that emits a point; the end point leaves
    // position and error as they are and closes the line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_end_x      <= '0;
            r_end_y      <= '0;
            r_abs_dx     <= '0;
            r_neg_abs_dy <= '0;
            r_step_x_neg <= 1'b0;
            r_step_y_neg <= 1'b0;
            r_err        <= '0;
            r_color      <= '0;
            r_active     <= 1'b0;
        end else if (fire && has_result) begin
            r_end_x      <= ex;
            r_end_y      <= ey;
            r_abs_dx     <= ax;
            r_neg_abs_dy <= nay;
            r_step_x_neg <= sxn;
            r_step_y_neg <= syn;
            r_color      <= color;
            r_active     <= !is_last;
            if (is_last) begin
                r_cur_x <= cx;
                r_cur_y <= cy;
                r_err   <= err;
            end else begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_err   <= n_err;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_result) begin
            o_px        <= cx;
            o_py        <= cy;
            o_color_out <= color;
            o_drawn     <= drawn;
            o_last      <= is_last;
        end
    end

    assign o_out_valid = r_out_vld;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && has_result && is_last) |=> !r_active)
        else $error("line still running after its end point");

    a_load_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && is_load) |=> o_out_valid)
        else $error("load request gave no point");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !is_load && !r_active) |=> !o_out_valid)
        else $error("step without a running line gave a point");

    a_step_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && has_result && !is_last) |=>
            ((r_cur_x != $past(cx)) || (r_cur_y != $past(cy))))
        else $error("line position did not advance");

endmodule

>>> src/clr_clip_test.sv
// ----------------------------------------------------------------------------
// clr_clip_test
// Drawn flag of one point: half-open clip rectangle, color key and the
// never-drawn color.
// ----------------------------------------------------------------------------
module clr_clip_test
    import clr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int CLIP_BITS  = 12
) (
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic [COLOR_BITS-1:0]        i_color,
    input  logic signed [CLIP_BITS-1:0]  i_clip_left,
    input  logic signed [CLIP_BITS-1:0]  i_clip_top,
    input  logic signed [CLIP_BITS-1:0]  i_clip_right,
    input  logic signed [CLIP_BITS-1:0]  i_clip_bottom,
    input  t_key_cfg                     i_key,
    output logic                         o_drawn
);

    logic signed [CLIP_BITS-1:0] xw;
    logic signed [CLIP_BITS-1:0] yw;
    logic                        in_clip;
    logic                        keyed;

    assign xw = CLIP_BITS'(i_x);
    assign yw = CLIP_BITS'(i_y);

    assign in_clip = (xw >= i_clip_left) && (xw < i_clip_right) &&
                     (yw >= i_clip_top)  && (yw < i_clip_bottom);
    assign keyed   = i_key.en && (i_key.value == i_color);

    assign o_drawn = in_clip && !keyed && (i_color != COLOR_NEVER_DRAWN);

endmodule
